>>> hdl/kabf_pkg.sv
`default_nettype none
package kabf_pkg;

   // datapath operation codes
   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV,
      OP_LD,
      OP_OUT
   } op_type;

   typedef logic [3:0] ridx_type;

   // working register file slots
   localparam ridx_type R_ANG  = 4'd0;
   localparam ridx_type R_BIAS = 4'd1;
   localparam ridx_type R_P00  = 4'd2;
   localparam ridx_type R_P01  = 4'd3;
   localparam ridx_type R_P10  = 4'd4;
   localparam ridx_type R_P11  = 4'd5;
   localparam ridx_type R_DT   = 4'd6;
   localparam ridx_type R_Y    = 4'd7;
   localparam ridx_type R_RATE = 4'd8;
   localparam ridx_type R_QA   = 4'd9;
   localparam ridx_type R_QB   = 4'd10;
   localparam ridx_type R_RN   = 4'd11;
   localparam ridx_type R_T0   = 4'd12;
   localparam ridx_type R_T1   = 4'd13;
   localparam ridx_type R_K0   = 4'd14;
   localparam ridx_type R_K1   = 4'd15;

   // configuration register indexes, byte address is 4 * index
   typedef logic [1:0] csr_idx_type;
   localparam csr_idx_type CSR_QA = 2'd0;
   localparam csr_idx_type CSR_QB = 2'd1;
   localparam csr_idx_type CSR_RN = 2'd2;

   typedef logic [5:0] step_type;

   typedef logic [4:0] count_type;
   localparam count_type DIV_LAST = 5'd31;

   // dt = round(ms * 65536 / 1000) through a reciprocal multiply
   localparam int          MS_PER_S = 1000;
   localparam logic [31:0] DT_BIAS  = 32'(MS_PER_S / 2);
   localparam logic [28:0] DT_MAGIC = 29'h10624DD3;
   localparam int          DT_SHIFT = 38;
   localparam int          DT_W     = 23;

   localparam logic signed [31:0] I32_MAX = 32'sh7FFFFFFF;
   localparam logic signed [31:0] I32_MIN = 32'sh80000000;

   typedef struct packed {
      op_type   op;
      ridx_type dst;
      ridx_type sa;
      ridx_type sb;
   } uop_type;

   typedef struct packed {
      logic    capture;
      logic    dt_load;
      logic    exec;
      logic    mul_wr;
      logic    div_step;
      logic    div_wr;
      logic    out_load;
      uop_type uop;
   } cmd_type;

   function automatic uop_type mk(op_type op, ridx_type dst, ridx_type sa, ridx_type sb);
      uop_type u;
      u.op  = op;
      u.dst = dst;
      u.sa  = sa;
      u.sb  = sb;
      return u;
   endfunction

   // micro program: load inputs, predict, correct, then read out angle and bias
   function automatic uop_type prog(step_type s);
      uop_type u;
      case (s)
         6'd0:    u = mk(OP_LD,  R_Y,    R_Y,    R_Y);
         6'd1:    u = mk(OP_LD,  R_RATE, R_RATE, R_RATE);
         6'd2:    u = mk(OP_LD,  R_DT,   R_DT,   R_DT);
         6'd3:    u = mk(OP_LD,  R_QA,   R_QA,   R_QA);
         6'd4:    u = mk(OP_LD,  R_QB,   R_QB,   R_QB);
         6'd5:    u = mk(OP_LD,  R_RN,   R_RN,   R_RN);
         6'd6:    u = mk(OP_SUB, R_T0,   R_RATE, R_BIAS);
         6'd7:    u = mk(OP_MUL, R_T0,   R_DT,   R_T0);
         6'd8:    u = mk(OP_ADD, R_ANG,  R_ANG,  R_T0);
         6'd9:    u = mk(OP_ADD, R_T0,   R_P10,  R_P01);
         6'd10:   u = mk(OP_SUB, R_T0,   R_QA,   R_T0);
         6'd11:   u = mk(OP_MUL, R_T0,   R_DT,   R_T0);
         6'd12:   u = mk(OP_ADD, R_P00,  R_P00,  R_T0);
         6'd13:   u = mk(OP_MUL, R_T0,   R_DT,   R_P11);
         6'd14:   u = mk(OP_SUB, R_P01,  R_P01,  R_T0);
         6'd15:   u = mk(OP_SUB, R_P10,  R_P10,  R_T0);
         6'd16:   u = mk(OP_MUL, R_T0,   R_DT,   R_QB);
         6'd17:   u = mk(OP_ADD, R_P11,  R_P11,  R_T0);
         6'd18:   u = mk(OP_SUB, R_Y,    R_Y,    R_ANG);
         6'd19:   u = mk(OP_ADD, R_T1,   R_P00,  R_RN);
         6'd20:   u = mk(OP_DIV, R_K0,   R_P00,  R_T1);
         6'd21:   u = mk(OP_DIV, R_K1,   R_P10,  R_T1);
         6'd22:   u = mk(OP_MUL, R_T0,   R_K0,   R_Y);
         6'd23:   u = mk(OP_ADD, R_ANG,  R_ANG,  R_T0);
         6'd24:   u = mk(OP_MUL, R_T0,   R_K1,   R_Y);
         6'd25:   u = mk(OP_ADD, R_BIAS, R_BIAS, R_T0);
         6'd26:   u = mk(OP_MUL, R_T0,   R_K0,   R_P00);
         6'd27:   u = mk(OP_SUB, R_P00,  R_P00,  R_T0);
         6'd28:   u = mk(OP_MUL, R_T0,   R_K0,   R_P01);
         6'd29:   u = mk(OP_SUB, R_P01,  R_P01,  R_T0);
         6'd30:   u = mk(OP_MUL, R_T0,   R_K1,   R_P00);
         6'd31:   u = mk(OP_SUB, R_P10,  R_P10,  R_T0);
         6'd32:   u = mk(OP_MUL, R_T0,   R_K1,   R_P01);
         6'd33:   u = mk(OP_SUB, R_P11,  R_P11,  R_T0);
         default: u = mk(OP_OUT, R_ANG,  R_ANG,  R_BIAS);
      endcase
      return u;
   endfunction

endpackage
`default_nettype wire

>>> hdl/kabf_datapath.sv
`default_nettype none
module kabf_datapath import kabf_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   input  wire logic signed [31:0] measured_angle,
   input  wire logic signed [31:0] measured_rate,
   input  wire logic        [15:0] elapsed_ms,
   input  wire logic        [30:0] angle_process_noise,
   input  wire logic        [30:0] bias_process_noise,
   input  wire logic        [30:0] measurement_noise,
   output logic signed      [31:0] filtered_angle,
   output logic signed      [31:0] estimated_bias
);

   function automatic logic signed [31:0] sat48(logic signed [47:0] v);
      if (v > 48'(I32_MAX)) return I32_MAX;
      if (v < 48'(I32_MIN)) return I32_MIN;
      return v[31:0];
   endfunction

   // register file
   logic        [31:0] mem [16];
   logic        [15:0] vld_ff, vld_in;
   logic        [31:0] rda_ff, rdb_ff;
   logic               rda_v_ff, rdb_v_ff;
   logic signed [31:0] opa, opb;

   logic               wr_en;
   logic signed [31:0] wr_data;

   // captured inputs
   logic signed [31:0] meas_ff, rate_ff;
   logic        [60:0] dtprod_ff;
   logic [DT_W-1:0]    dt_ff;

   // multiplier
   logic signed [63:0] prod_ff;
   logic signed [63:0] prod_rnd;
   logic signed [31:0] mul_res;

   // divider
   logic        [31:0] rem_ff, lo_ff, quo_ff;
   logic        [30:0] dsor_ff;
   logic               neg_ff, ovf_ff, dzero_ff;
   logic        [31:0] absa;
   logic        [47:0] num48;
   logic        [32:0] trial, diff;
   logic               ge;
   logic signed [31:0] div_res;

   logic signed [32:0] sum33, dif33;
   logic signed [31:0] ext_val;

   logic signed [31:0] ang_out_ff, bias_out_ff;

   assign opa = rda_v_ff ? signed'(rda_ff) : 32'sd0;
   assign opb = rdb_v_ff ? signed'(rdb_ff) : 32'sd0;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[cmd.uop.dst] <= wr_data;
      end
      rda_ff <= mem[cmd.uop.sa];
      rdb_ff <= mem[cmd.uop.sb];
   end

   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[cmd.uop.dst] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         rda_v_ff <= 1'b0;
         rdb_v_ff <= 1'b0;
      end else begin
         vld_ff   <= vld_in;
         rda_v_ff <= vld_ff[cmd.uop.sa];
         rdb_v_ff <= vld_ff[cmd.uop.sb];
      end
   end

   // input capture and time step
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         meas_ff   <= measured_angle;
         rate_ff   <= measured_rate;
         dtprod_ff <= ({elapsed_ms, 16'd0} + DT_BIAS) * DT_MAGIC;
      end
      if (cmd.dt_load) begin
         dt_ff <= dtprod_ff[DT_SHIFT+DT_W-1:DT_SHIFT];
      end
   end

   always_comb begin
      case (cmd.uop.dst)
         R_Y:     ext_val = meas_ff;
         R_RATE:  ext_val = rate_ff;
         R_DT:    ext_val = signed'({{(32-DT_W){1'b0}}, dt_ff});
         R_QA:    ext_val = signed'({1'b0, angle_process_noise});
         R_QB:    ext_val = signed'({1'b0, bias_process_noise});
         R_RN:    ext_val = signed'({1'b0, measurement_noise});
         default: ext_val = 32'sd0;
      endcase
   end

   // add and subtract with saturation
   assign sum33 = 33'(opa) + 33'(opb);
   assign dif33 = 33'(opa) - 33'(opb);

   // multiply, then round to nearest and saturate in the next cycle
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         prod_ff <= opa * opb;
      end
   end
   assign prod_rnd = prod_ff + 64'sd32768;
   assign mul_res  = sat48(prod_rnd[63:16]);

   // restoring divider, one quotient bit per cycle
   assign absa  = opa[31] ? 32'(-opa) : 32'(opa);
   assign num48 = {absa, 16'd0} + {17'd0, opb[31:1]};
   assign trial = {rem_ff, lo_ff[31]};
   assign diff  = trial - {2'b00, dsor_ff};
   assign ge    = trial >= {2'b00, dsor_ff};

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         dzero_ff <= opb[31] || (opb == 32'sd0);
         neg_ff   <= opa[31];
         ovf_ff   <= {16'd0, num48[47:32]} >= 32'(opb);
         rem_ff   <= {16'd0, num48[47:32]};
         lo_ff    <= num48[31:0];
         dsor_ff  <= opb[30:0];
         quo_ff   <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= ge ? diff[31:0] : trial[31:0];
         lo_ff  <= {lo_ff[30:0], 1'b0};
         quo_ff <= {quo_ff[30:0], ge};
      end
   end

   always_comb begin
      if (dzero_ff) begin
         div_res = 32'sd0;
      end else if (ovf_ff) begin
         div_res = neg_ff ? I32_MIN : I32_MAX;
      end else if (neg_ff) begin
         div_res = (quo_ff > 32'h80000000) ? I32_MIN : signed'(32'(-quo_ff));
      end else begin
         div_res = quo_ff[31] ? I32_MAX : signed'(quo_ff);
      end
   end

   // write-back selection
   always_comb begin
      wr_en   = 1'b0;
      wr_data = mul_res;
      if (cmd.mul_wr) begin
         wr_en   = 1'b1;
         wr_data = mul_res;
      end else if (cmd.div_wr) begin
         wr_en   = 1'b1;
         wr_data = div_res;
      end else if (cmd.exec) begin
         case (cmd.uop.op)
            OP_ADD: begin
               wr_en   = 1'b1;
               wr_data = sat48(48'(sum33));
            end
            OP_SUB: begin
               wr_en   = 1'b1;
               wr_data = sat48(48'(dif33));
            end
            OP_LD: begin
               wr_en   = 1'b1;
               wr_data = ext_val;
            end
            default: begin
               wr_en   = 1'b0;
               wr_data = ext_val;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         ang_out_ff  <= opa;
         bias_out_ff <= opb;
      end
   end

   assign filtered_angle = ang_out_ff;
   assign estimated_bias = bias_out_ff;

endmodule
`default_nettype wire

>>> hdl/kabf_ctrl.sv
`default_nettype none
module kabf_ctrl import kabf_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output cmd_type   cmd
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_DT    = 8'b0000_0010,
      ST_ISSUE = 8'b0000_0100,
      ST_EXEC  = 8'b0000_1000,
      ST_MULW  = 8'b0001_0000,
      ST_DIVS  = 8'b0010_0000,
      ST_DIVW  = 8'b0100_0000,
      ST_OUTW  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   count_type cnt_ff, cnt_in;
   logic      rsp_valid_ff, rsp_valid_in;
   uop_type   uop;

   assign uop = prog(step_ff);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.uop      = uop;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DT;
            end
         end
         ST_DT: begin
            cmd.dt_load = 1'b1;
            step_in     = '0;
            state_in    = ST_ISSUE;
         end
         ST_ISSUE: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = (uop.op != OP_OUT);
            case (uop.op)
               OP_MUL: state_in = ST_MULW;
               OP_DIV: begin
                  cnt_in   = '0;
                  state_in = ST_DIVS;
               end
               OP_OUT: state_in = ST_OUTW;
               default: begin
                  step_in  = step_ff + 6'd1;
                  state_in = ST_ISSUE;
               end
            endcase
         end
         ST_MULW: begin
            cmd.mul_wr = 1'b1;
            step_in    = step_ff + 6'd1;
            state_in   = ST_ISSUE;
         end
         ST_DIVS: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 5'd1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_DIVW;
            end
         end
         ST_DIVW: begin
            cmd.div_wr = 1'b1;
            step_in    = step_ff + 6'd1;
            state_in   = ST_ISSUE;
         end
         ST_OUTW: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

>>> hdl/kalman_angle_bias_filter_core.sv
`default_nettype none
// channel   dir  handshake              payload
// req       in   req_tvalid/req_tready  measured_angle, measured_rate, elapsed_ms
// rsp       out  rsp_tvalid/rsp_tready  filtered_angle, estimated_bias
// csr       in   apb, pready tied high  angle/bias process noise, measurement noise
//
// one transaction at a time, sequenced by the 35-step micro program on one
// shared add/multiply/divide datapath; the two gain divisions go through the
// bit-serial divider; reset is synchronous and restores the noise defaults;
// it also clears the control state and the register file valid bits
// the result sits in an output register, so the next request is taken while it waits;
// a stalled response only holds the controller at the final read-out step
module kalman_angle_bias_filter_core import kabf_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [31:0] measured_angle, [63:32] measured_rate, [79:64] elapsed_ms
   input  wire logic [79:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [31:0] filtered_angle, [63:32] estimated_bias
   output logic      [63:0] rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   // configuration registers
   logic [30:0] qa_ff, qb_ff, rn_ff;
   logic        csr_wr;
   cmd_type     cmd;

   logic signed [31:0] filtered_angle, estimated_bias;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // write keeps the low 31 bits, a write beyond the register list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         qa_ff <= 31'd66;
         qb_ff <= 31'd197;
         rn_ff <= 31'd1966;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            CSR_QA:  qa_ff <= csr_pwdata[30:0];
            CSR_QB:  qb_ff <= csr_pwdata[30:0];
            CSR_RN:  rn_ff <= csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         CSR_QA:  csr_prdata = {1'b0, qa_ff};
         CSR_QB:  csr_prdata = {1'b0, qb_ff};
         CSR_RN:  csr_prdata = {1'b0, rn_ff};
         default: csr_prdata = 32'd0;
      endcase
   end

   // sequencer
   kabf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .cmd       (cmd)
   );

   // register file, arithmetic units and output register
   kabf_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .measured_angle      (signed'(req_tdata[31:0])),
      .measured_rate       (signed'(req_tdata[63:32])),
      .elapsed_ms          (req_tdata[79:64]),
      .angle_process_noise (qa_ff),
      .bias_process_noise  (qb_ff),
      .measurement_noise   (rn_ff),
      .filtered_angle      (filtered_angle),
      .estimated_bias      (estimated_bias)
   );

   assign rsp_tdata = {estimated_bias, filtered_angle};

   // at most one write-back source per cycle
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.exec, cmd.mul_wr, cmd.div_wr}))
      else $error("write-back sources collide");

   // an accepted request closes the input until the sequence finishes
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while busy");

   // the output register is only loaded when it is free or being drained
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_tvalid || rsp_tready))
      else $error("pending response overwritten");

   // no response leaves right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule
`default_nettype wire

>>> tb/kalman_angle_bias_filter_core_test.sv
`timescale 1ns / 1ps
module kalman_angle_bias_filter_core_test import kabf_pkg::*;;

   // register indexes, byte address is 4 * index
   localparam int REG_ANGLE_NOISE = int'(CSR_QA);
   localparam int REG_BIAS_NOISE  = int'(CSR_QB);
   localparam int REG_MEAS_NOISE  = int'(CSR_RN);
   localparam int REG_UNUSED      = 3;
   localparam int IDLE_LIMIT      = 6000;
   localparam int MAX_REPORTS     = 10;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // [31:0] measured_angle, [63:32] measured_rate, [79:64] elapsed_ms
   logic [79:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // [31:0] filtered_angle, [63:32] estimated_bias
   logic [63:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   typedef struct packed {
      logic signed [31:0] bias;
      logic signed [31:0] angle;
   } estimate_type;

   // filter state mirror
   int          angle_est, bias_est, p00, p01, p10, p11;
   logic [30:0] q_angle, q_bias, r_meas;

   estimate_type estimate_queue[$];
   int          mismatches;
   int          results_seen;
   int          zero_gain_items;
   int          idle_cycles;
   bit          idling_on;
   bit          hold_request;

   kalman_angle_bias_filter_core uut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int sat32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFFFFFF;
      if (v < -64'sd2147483648) return 32'h80000000;
      return int'(v);
   endfunction

   // product rounds half up: floor((a*b + half) / one)
   function automatic int mul_q16(int a, int b);
      longint p;
      p = longint'(a) * longint'(b) + 64'sd32768;
      return sat32(p >>> 16);
   endfunction

   // quotient rounds half away from zero, zero on a nonpositive divisor
   function automatic int div_q16(int a, int s);
      longint num, mag;
      if (s <= 0) return 0;
      num = longint'(a) * 64'sd65536;
      mag = ((num < 0 ? -num : num) + longint'(s) / 2) / longint'(s);
      return sat32(num < 0 ? -mag : mag);
   endfunction

   // one predict and correct pass of the two-state filter
   function automatic estimate_type filter_update(logic [79:0] d);
      int meas, rate, dt, innov, s, k0, k1;
      estimate_type e;
      meas = d[31:0];
      rate = d[63:32];
      dt = int'((longint'(d[79:64]) * 65536 + 500) / 1000);
      angle_est = sat32(longint'(angle_est) + mul_q16(dt, sat32(longint'(rate) - bias_est)));
      p00 = sat32(longint'(p00) + mul_q16(dt, sat32(longint'(int'({1'b0, q_angle}))
                                                  - sat32(longint'(p10) + p01))));
      p01 = sat32(longint'(p01) - mul_q16(dt, p11));
      p10 = sat32(longint'(p10) - mul_q16(dt, p11));
      p11 = sat32(longint'(p11) + mul_q16(dt, int'({1'b0, q_bias})));
      innov = sat32(longint'(meas) - angle_est);
      s = sat32(longint'(p00) + int'({1'b0, r_meas}));
      if (s <= 0) zero_gain_items++;
      k0 = div_q16(p00, s);
      k1 = div_q16(p10, s);
      angle_est = sat32(longint'(angle_est) + mul_q16(k0, innov));
      bias_est = sat32(longint'(bias_est) + mul_q16(k1, innov));
      // later rows use the entries already corrected
      p00 = sat32(longint'(p00) - mul_q16(k0, p00));
      p01 = sat32(longint'(p01) - mul_q16(k0, p01));
      p10 = sat32(longint'(p10) - mul_q16(k1, p00));
      p11 = sat32(longint'(p11) - mul_q16(k1, p01));
      e.angle = angle_est;
      e.bias = bias_est;
      return e;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      if (!idling_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // predict on each accepted request transaction
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         estimate_queue.push_back(filter_update(req_tdata));
   end

   // compare each accepted response transaction with the oldest prediction
   always @(posedge clock) begin
      estimate_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         results_seen++;
         if (estimate_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result: angle %h bias %h", got.angle, got.bias);
         end else begin
            want = estimate_queue.pop_front();
            if (got.angle !== want.angle || got.bias !== want.bias) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("result %0d: angle exp %h got %h, bias exp %h got %h",
                           results_seen, want.angle, got.angle, want.bias, got.bias);
            end
         end
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   always @(negedge clock) begin
      int gap, hold;
      if (reset) begin
         rsp_tready = 1'b1;
      end else if (hold_request && hold == 0) begin
         hold = 400;
         hold_request = 1'b0;
         rsp_tready = 1'b0;
      end else if (hold > 0) begin
         hold--;
         rsp_tready = (hold == 0);
      end else if (gap > 0) begin
         gap--;
         rsp_tready = (gap == 0);
      end else begin
         gap = pick_gap();
         rsp_tready = (gap == 0);
      end
   end

   // watchdog on cycles without any accepted transaction or register access
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         idle_cycles = 0;
      else if (++idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_item(logic [31:0] angle, logic [31:0] rate, logic [15:0] ms);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata = {ms, rate, angle};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid = 1'b0;
      while (estimate_queue.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(int idx, logic [31:0] value);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_penable = 1'b0;
      csr_paddr = 4'(4 * idx);
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      case (idx)
         REG_ANGLE_NOISE: q_angle = value[30:0];
         REG_BIAS_NOISE:  q_bias = value[30:0];
         REG_MEAS_NOISE:  r_meas = value[30:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task automatic csr_check(int idx);
      logic [31:0] want;
      case (idx)
         REG_ANGLE_NOISE: want = {1'b0, q_angle};
         REG_BIAS_NOISE:  want = {1'b0, q_bias};
         default:         want = {1'b0, r_meas};
      endcase
      csr_psel = 1'b1;
      csr_pwrite = 1'b0;
      csr_paddr = 4'(4 * idx);
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      if (csr_prdata !== want) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("register %0d: exp %h got %h", idx, want, csr_prdata);
      end
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic write_noise(logic [31:0] qa, logic [31:0] qb, logic [31:0] rn);
      csr_write(REG_ANGLE_NOISE, qa);
      csr_write(REG_BIAS_NOISE, qb);
      csr_write(REG_MEAS_NOISE, rn);
   endtask

   // imu sample, 1 in 10 random: angle in a turn, rate within 500 deg/s, step to 2 s
   task automatic send_sample();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         send_item($urandom, $urandom, 16'($urandom));
      else
         send_item($urandom_range(0, 360 << 16) - (180 << 16),
                   $urandom_range(0, 1000 << 16) - (500 << 16),
                   (r == 1) ? 16'($urandom_range(0, 2000)) : 16'($urandom_range(1, 50)));
   endtask

   // readback and write masking, unknown index ignored
   task automatic test_registers();
      write_noise(32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF);
      csr_write(REG_UNUSED, 32'h12345678);
      for (int i = 0; i < 3; i++) csr_check(i);
      write_noise(32'd66, 32'd197, 32'd1966);
      for (int i = 0; i < 3; i++) csr_check(i);
   endtask

   // field extremes, zero step, longest step and gains forced to zero
   task automatic test_directed();
      send_item(32'h0, 32'h0, 16'd0);
      send_item(32'h7FFFFFFF, 32'h0, 16'd10);
      send_item(32'h80000000, 32'h7FFFFFFF, 16'd65535);
      send_item(32'h7FFFFFFF, 32'h80000000, 16'd65535);
      send_item(32'h00010000, 32'hFFFF0000, 16'd1);
      send_item(32'hFFFFFFFF, 32'h00000001, 16'd499);
      send_item(32'h80000000, 32'h80000000, 16'd500);
      drain();
      // zero measurement noise with zero covariance leaves no innovation variance
      write_noise(32'd0, 32'd0, 32'd0);
      send_item(32'h00050000, 32'h00010000, 16'd0);
      send_item(32'hFFFB0000, 32'h7FFFFFFF, 16'd0);
      send_item(32'h00000000, 32'h00000000, 16'd20);
      drain();
      write_noise(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      send_item(32'h7FFFFFFF, 32'h7FFFFFFF, 16'd65535);
      send_item(32'h80000000, 32'h80000000, 16'd65535);
      send_item(32'h0, 32'h0, 16'd1);
      drain();
   endtask

   // random samples across several noise settings
   task automatic test_random(int count);
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: write_noise(32'd66, 32'd197, 32'd1966);
            1: write_noise(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
            2: write_noise(32'd0, 32'd0, 32'd0);
            3: write_noise($urandom_range(0, 4000), $urandom_range(0, 4000),
                           $urandom_range(0, 70000));
            default: write_noise($urandom, $urandom, $urandom);
         endcase
         idling_on = (phase != 3);
         for (int i = 0; i < count / 5; i++) send_sample();
         drain();
      end
      idling_on = 1'b1;
   endtask

   // long receiver hold-off while requests keep coming
   task automatic test_backpressure();
      write_noise(32'd66, 32'd197, 32'd1966);
      hold_request = 1'b1;
      for (int i = 0; i < 12; i++) send_sample();
      drain();
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      hold_request = 1'b0;
      idling_on = 1'b1;
      mismatches = 0;
      results_seen = 0;
      zero_gain_items = 0;
      angle_est = 0; bias_est = 0; p00 = 0; p01 = 0; p10 = 0; p11 = 0;
      q_angle = 31'd66; q_bias = 31'd197; r_meas = 31'd1966;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      test_registers();
      test_directed();
      test_backpressure();
      test_random(1100);
      drain();
      repeat (200) @(negedge clock);

      $display("covered %0d results, %0d with no innovation variance, five noise settings",
               results_seen, zero_gain_items);
      $display("plus register readback and a long response hold-off; %0d mismatches",
               mismatches);
      if (mismatches == 0 && estimate_queue.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
